[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that prop holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that ante implies cons in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that ante implies cons in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(label, prop, msg)
`define ASSERT_IMPLY(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[src/twla_pkg.sv]
// ----------------------------------------------------------------------------
// twla_pkg
// Shared types and codes for the two-level alert with dwell.
// ----------------------------------------------------------------------------
package twla_pkg;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } opcode_e;

  // Severity levels
  localparam logic [1:0] LEVEL_NONE = 2'd0;
  localparam logic [1:0] LEVEL_WARN = 2'd1;
  localparam logic [1:0] LEVEL_CRIT = 2'd2;

  // Pending change kinds
  localparam logic [1:0] PEND_NONE      = 2'd0;
  localparam logic [1:0] PEND_RISE_WARN = 2'd1;
  localparam logic [1:0] PEND_RISE_CRIT = 2'd2;
  localparam logic [1:0] PEND_RELEASE   = 2'd3;

  // Configuration register map
  localparam int unsigned CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] CFG_WATCHED_SENSOR = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_MODE_FLAGS     = 4'd1;
  localparam logic [CfgIdxW-1:0] CFG_WARNING_LIMIT  = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_CRITICAL_LIMIT = 4'd3;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE_MARGIN = 4'd4;
  localparam logic [CfgIdxW-1:0] CFG_RISE_DWELL     = 4'd5;
  localparam logic [CfgIdxW-1:0] CFG_FALL_DWELL     = 4'd6;
  localparam logic [CfgIdxW-1:0] CFG_STALE_LIMIT    = 4'd7;

  // Mode flag bit positions
  localparam int unsigned MODE_ABOVE   = 0;
  localparam int unsigned MODE_WARN_EN = 1;
  localparam int unsigned MODE_CRIT_EN = 2;

  typedef struct packed {
    logic [7:0]         watched_sensor;
    logic [2:0]         mode_flags;
    logic signed [31:0] warning_limit;
    logic signed [31:0] critical_limit;
    logic [30:0]        release_margin;
    logic [31:0]        rise_dwell_ms;
    logic [31:0]        fall_dwell_ms;
    logic [31:0]        stale_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  level;
    logic [1:0]  pending;
    logic [31:0] pending_start;
    logic [31:0] last_seen;
    logic        seen_any;
  } rule_state_t;

  typedef struct packed {
    logic [1:0] severity;
    logic [1:0] pending_kind;
    logic       unavailable;
  } result_t;

endpackage

[src/twla_cfg.sv]
// ----------------------------------------------------------------------------
// twla_cfg
// Configuration register file; every write is taken at once.
// ----------------------------------------------------------------------------
module twla_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [twla_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  output twla_pkg::cfg_t                cfg_o
);
  import twla_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WATCHED_SENSOR: cfg_q.watched_sensor <= cfg_data_i[7:0];
        CFG_MODE_FLAGS:     cfg_q.mode_flags     <= cfg_data_i[2:0];
        CFG_WARNING_LIMIT:  cfg_q.warning_limit  <= cfg_data_i;
        CFG_CRITICAL_LIMIT: cfg_q.critical_limit <= cfg_data_i;
        CFG_RELEASE_MARGIN: cfg_q.release_margin <= cfg_data_i[30:0];
        CFG_RISE_DWELL:     cfg_q.rise_dwell_ms  <= cfg_data_i;
        CFG_FALL_DWELL:     cfg_q.fall_dwell_ms  <= cfg_data_i;
        CFG_STALE_LIMIT:    cfg_q.stale_limit_ms <= cfg_data_i;
        default:            ; // unmapped index: drop the write
      endcase
    end
  end

endmodule

[src/twla_core.sv]
// ----------------------------------------------------------------------------
// twla_core
// Next-state and result logic for one sample or tick.
// ----------------------------------------------------------------------------
module twla_core (
  input  twla_pkg::cfg_t        cfg_i,
  input  twla_pkg::rule_state_t state_i,
  input  logic                  opcode_i,
  input  logic [7:0]            sensor_id_i,
  input  logic signed [31:0]    reading_i,
  input  logic [31:0]           time_ms_i,
  output twla_pkg::rule_state_t state_o,
  output twla_pkg::result_t     result_o
);
  import twla_pkg::*;

  logic               above;
  logic [31:0]        gap_seen;
  logic               gap_stale;
  logic               sample_stale;
  logic               tick_stale;
  logic [1:0]         pend0;
  logic [31:0]        pstart0;
  logic [31:0]        elapsed;
  logic               crit_hit;
  logic               warn_hit;
  logic [1:0]         target;
  logic signed [31:0] active_lim;
  logic signed [32:0] lim33;
  logic signed [32:0] margin33;
  logic signed [32:0] val33;
  logic signed [32:0] rel_lo;
  logic signed [32:0] rel_hi;
  logic               releases;
  rule_state_t        samp_st;

  assign above     = cfg_i.mode_flags[MODE_ABOVE];
  assign gap_seen  = time_ms_i - state_i.last_seen;
  assign gap_stale = gap_seen > cfg_i.stale_limit_ms;

  assign sample_stale = state_i.seen_any && gap_stale;
  assign tick_stale   = !state_i.seen_any || gap_stale;

  // Drop the pending change after a stale gap
  assign pend0   = sample_stale ? PEND_NONE : state_i.pending;
  assign pstart0 = sample_stale ? '0 : state_i.pending_start;
  assign elapsed = time_ms_i - pstart0;

  assign crit_hit = above ? (reading_i >= cfg_i.critical_limit)
                          : (reading_i <= cfg_i.critical_limit);
  assign warn_hit = above ? (reading_i >= cfg_i.warning_limit)
                          : (reading_i <= cfg_i.warning_limit);

  always_comb begin
    if (cfg_i.mode_flags[MODE_CRIT_EN] && crit_hit) begin
      target = LEVEL_CRIT;
    end else if (cfg_i.mode_flags[MODE_WARN_EN] && warn_hit) begin
      target = LEVEL_WARN;
    end else begin
      target = LEVEL_NONE;
    end
  end

  // Release threshold at 33 bits so limit +/- margin never wraps
  assign active_lim = (state_i.level == LEVEL_CRIT) ? cfg_i.critical_limit
                                                    : cfg_i.warning_limit;
  assign lim33    = {active_lim[31], active_lim};
  assign margin33 = {2'b00, cfg_i.release_margin};
  assign val33    = {reading_i[31], reading_i};
  assign rel_lo   = lim33 - margin33;
  assign rel_hi   = lim33 + margin33;
  assign releases = above ? (val33 <= rel_lo) : (val33 >= rel_hi);

  always_comb begin
    samp_st               = state_i;
    samp_st.pending       = pend0;
    samp_st.pending_start = pstart0;
    samp_st.seen_any      = 1'b1;
    samp_st.last_seen     = time_ms_i;
    if (target > state_i.level) begin
      if (pend0 != target) begin
        samp_st.pending       = target;
        samp_st.pending_start = time_ms_i;
      end else if (elapsed >= cfg_i.rise_dwell_ms) begin
        samp_st.level   = target;
        samp_st.pending = PEND_NONE;
      end
    end else if (target < state_i.level) begin
      if (!releases) begin
        samp_st.pending = PEND_NONE;
      end else if (pend0 != PEND_RELEASE) begin
        samp_st.pending       = PEND_RELEASE;
        samp_st.pending_start = time_ms_i;
      end else if (elapsed >= cfg_i.fall_dwell_ms) begin
        samp_st.level   = target;
        samp_st.pending = PEND_NONE;
      end
    end else begin
      samp_st.pending = PEND_NONE;
    end
  end

  always_comb begin
    state_o              = state_i;
    result_o.unavailable = 1'b0;
    if (opcode_i == OP_TICK) begin
      if (tick_stale) begin
        state_o.pending = PEND_NONE;
      end
      result_o.unavailable = tick_stale && (state_i.level != LEVEL_NONE);
    end else if (sensor_id_i == cfg_i.watched_sensor) begin
      state_o = samp_st;
    end
    result_o.severity     = state_o.level;
    result_o.pending_kind = state_o.pending;
  end

endmodule

[src/two_level_alert_with_dwell.sv]
// ----------------------------------------------------------------------------
// two_level_alert_with_dwell
// An accepted input word passes through the input register, then the result
// register, where the result word is valid; an output stall holds it there.
// Throughput: one item per cycle while the output is not stalled, set by the
// state update in the core logic. Reset: asynchronous active low;
// clears rule state, configuration and both valid flags.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module two_level_alert_with_dwell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [twla_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  // Input word
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         opcode_i,
  input  logic [7:0]                   sensor_id_i,
  input  logic signed [31:0]           reading_i,
  input  logic [31:0]                  time_ms_i,
  // Result word
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   severity_o,
  output logic [1:0]                   pending_kind_o,
  output logic                         unavailable_o
);
  import twla_pkg::*;

  cfg_t               cfg;

  // Input register
  logic               s1_valid_q;
  logic               s1_op_q;
  logic [7:0]         s1_id_q;
  logic signed [31:0] s1_reading_q;
  logic [31:0]        s1_time_q;

  // Rule state and result register
  rule_state_t        state_q;
  rule_state_t        state_d;
  result_t            res_d;
  result_t            res_q;
  logic               out_valid_q;

  logic               in_take;
  logic               advance;

  twla_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  twla_core u_core (
    .cfg_i       (cfg),
    .state_i     (state_q),
    .opcode_i    (s1_op_q),
    .sensor_id_i (s1_id_q),
    .reading_i   (s1_reading_q),
    .time_ms_i   (s1_time_q),
    .state_o     (state_d),
    .result_o    (res_d)
  );

  // Evaluate the held word whenever the result register is free or draining;
  // the state commits on the same edge, so the next word sees it directly.
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  // Stall only when the input register is full and cannot move on
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Payload registers: load on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_op_q      <= opcode_i;
      s1_id_q      <= sensor_id_i;
      s1_reading_q <= reading_i;
      s1_time_q    <= time_ms_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign severity_o     = res_q.severity;
  assign pending_kind_o = res_q.pending_kind;
  assign unavailable_o  = res_q.unavailable;

  // A rise to warning is only ever pending from no severity
  `ASSERT_IMPLY(a_rise_warn_from_none, state_q.pending == PEND_RISE_WARN,
                state_q.level == LEVEL_NONE, "rise to warning pending above none")
  // A release is only ever pending while some severity is active
  `ASSERT_IMPLY(a_release_needs_level, state_q.pending == PEND_RELEASE,
                state_q.level != LEVEL_NONE, "release pending with no severity")
  // Nothing can be pending before the first watched sample
  `ASSERT_IMPLY(a_no_pending_unseen, !state_q.seen_any,
                state_q.pending == PEND_NONE && state_q.level == LEVEL_NONE,
                "pending or severity set before any sample")
  // An evaluated word always lands in the result register
  `ASSERT_NEXT(a_advance_fills_out, advance, out_valid_q, "result lost after evaluation")

endmodule
